/* rtl/uartrb_pkg.sv */
// ----------------------------------------------------------------------------
// uartrb_pkg
// Shared types and constants for the serial port transmit and receive
// ring buffer block: operation codes, field widths and the result record.
// ----------------------------------------------------------------------------
package uartrb_pkg;

    localparam int KIND_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 7;

    // byte returned by a get when the receive queue holds nothing
    localparam logic [BYTE_W-1:0] EMPTY_READ = 8'hFF;

    // operation codes; the three remaining codes are no-ops
    typedef enum logic [KIND_W-1:0] {
        KIND_PUT    = 3'd0,
        KIND_GET    = 3'd1,
        KIND_RX     = 3'd2,
        KIND_TXDONE = 3'd3,
        KIND_FLUSH  = 3'd4
    } kind_t;

    // per-cycle queue control from the top level to one ring
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic [BYTE_W-1:0] wdata;
    } ring_ctrl_t;

    // one result record
    typedef struct packed {
        logic [BYTE_W-1:0]  read_byte;
        logic               send_valid;
        logic [BYTE_W-1:0]  send_byte;
        logic               push_dropped;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
    } rsp_t;

endpackage

/* rtl/uartrb_req_if.sv */
// ----------------------------------------------------------------------------
// uartrb_req_if
// Request channel: one operation per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface uartrb_req_if;

    logic                           valid;
    logic                           ready;
    logic [uartrb_pkg::KIND_W-1:0]  kind;
    logic [uartrb_pkg::BYTE_W-1:0]  data;
    logic                           line_idle;

    modport source (
        output valid,
        output kind,
        output data,
        output line_idle,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  data,
        input  line_idle,
        output ready
    );

endinterface

/* rtl/uartrb_rsp_if.sv */
// ----------------------------------------------------------------------------
// uartrb_rsp_if
// Result channel: one result record per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface uartrb_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [uartrb_pkg::BYTE_W-1:0]  read_byte;
    logic                           send_valid;
    logic [uartrb_pkg::BYTE_W-1:0]  send_byte;
    logic                           push_dropped;
    logic [uartrb_pkg::LEVEL_W-1:0] rx_level;
    logic [uartrb_pkg::LEVEL_W-1:0] tx_level;

    modport source (
        output valid,
        output read_byte,
        output send_valid,
        output send_byte,
        output push_dropped,
        output rx_level,
        output tx_level,
        input  ready
    );

    modport sink (
        input  valid,
        input  read_byte,
        input  send_valid,
        input  send_byte,
        input  push_dropped,
        input  rx_level,
        input  tx_level,
        output ready
    );

endinterface

/* rtl/uartrb_ram.sv */
// ----------------------------------------------------------------------------
// uartrb_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module uartrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/uartrb_ring.sv */
// ----------------------------------------------------------------------------
// uartrb_ring
// One byte ring buffer: write and read pointers, fill count and a RAM.
// The RAM is always reading the entry the read pointer will hold next, so
// the head byte is ready in the cycle an operation arrives; a write to that
// entry in the previous cycle is forwarded past the RAM.
// ----------------------------------------------------------------------------
module uartrb_ring #(
    parameter int DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  uartrb_pkg::ring_ctrl_t          ctrl,
    output logic [uartrb_pkg::BYTE_W-1:0]   head,
    output logic [$clog2(DEPTH+1)-1:0]      fill,
    output logic [$clog2(DEPTH+1)-1:0]      fill_after
);

    import uartrb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic              fwd_reg, fwd_next;
    logic [BYTE_W-1:0] fwd_data_reg;
    logic [BYTE_W-1:0] ram_q;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (ctrl.clear)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            fill_next   = '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (ctrl.pop)
            begin
                rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
            end
            fill_next = fill_reg + FW'(ctrl.push) - FW'(ctrl.pop);
        end
    end

    // forward a byte written to the entry the RAM reads this cycle
    assign fwd_next = ctrl.push && (wr_ptr_reg == rd_ptr_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            fwd_reg    <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ctrl.wdata;
    end

    uartrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.push),
        .waddr (wr_ptr_reg),
        .wdata (ctrl.wdata),
        .raddr (rd_ptr_next),
        .rdata (ram_q)
    );

    assign head       = fwd_reg ? fwd_data_reg : ram_q;
    assign fill       = fill_reg;
    assign fill_after = fill_next;

endmodule

/* rtl/uart_tx_rx_ring_buffers.sv */
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers
// Transmit and receive byte queues between software and a serial line.
// Each request is decoded against the queue heads and fill counts and its
// result is captured in an output register.
// ----------------------------------------------------------------------------
// a result is registered and valid the cycle after its request transfer
// throughput: one request per cycle while results are taken; the output register frees as it is taken
// rate is set by the single pass through the queue decode and head read
// reset: pointers, fill counts and the output valid clear at once
// queue storage is not cleared; only bytes written since reset or flush are read
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    uartrb_req_if.sink   req,
    uartrb_rsp_if.source rsp
);

    import uartrb_pkg::*;

    localparam int RX_FW = $clog2(RX_DEPTH + 1);
    localparam int TX_FW = $clog2(TX_DEPTH + 1);

    logic              accept;
    ring_ctrl_t        rx_ctrl, tx_ctrl;
    logic [BYTE_W-1:0] rx_head, tx_head;
    logic [RX_FW-1:0]  rx_fill, rx_fill_after;
    logic [TX_FW-1:0]  tx_fill, tx_fill_after;
    logic              rx_full, rx_empty, tx_full, tx_empty;
    rsp_t              rsp_reg, rsp_next;
    logic              valid_reg;

    assign accept   = req.valid && req.ready;
    assign req.ready = !valid_reg || rsp.ready;

    assign rx_full  = (rx_fill == RX_FW'(RX_DEPTH));
    assign rx_empty = (rx_fill == '0);
    assign tx_full  = (tx_fill == TX_FW'(TX_DEPTH));
    assign tx_empty = (tx_fill == '0);

    // operation decode and result build
    always_comb
    begin
        rx_ctrl       = '0;
        tx_ctrl       = '0;
        rx_ctrl.wdata = req.data;
        tx_ctrl.wdata = req.data;
        rsp_next      = '0;
        if (accept)
        begin
            case (kind_t'(req.kind))
                KIND_PUT:
                begin
                    tx_ctrl.push          = !tx_full;
                    rsp_next.push_dropped = tx_full;
                    // with the line idle, an empty queue passes the new byte straight to the line
                    tx_ctrl.pop           = req.line_idle;
                    rsp_next.send_valid   = req.line_idle;
                    if (req.line_idle)
                    begin
                        rsp_next.send_byte = tx_empty ? req.data : tx_head;
                    end
                end
                KIND_GET:
                begin
                    rx_ctrl.pop        = !rx_empty;
                    rsp_next.read_byte = rx_empty ? EMPTY_READ : rx_head;
                end
                KIND_RX:
                begin
                    rx_ctrl.push          = !rx_full;
                    rsp_next.push_dropped = rx_full;
                end
                KIND_TXDONE:
                begin
                    tx_ctrl.pop         = !tx_empty;
                    rsp_next.send_valid = !tx_empty;
                    if (!tx_empty)
                    begin
                        rsp_next.send_byte = tx_head;
                    end
                end
                KIND_FLUSH:
                begin
                    rx_ctrl.clear = 1'b1;
                    tx_ctrl.clear = 1'b1;
                end
                default:
                begin
                    rsp_next.push_dropped = 1'b0;
                end
            endcase
        end
        rsp_next.rx_level = LEVEL_W'(rx_fill_after);
        rsp_next.tx_level = LEVEL_W'(tx_fill_after);
    end

    uartrb_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (rx_ctrl),
        .head       (rx_head),
        .fill       (rx_fill),
        .fill_after (rx_fill_after)
    );

    uartrb_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (tx_ctrl),
        .head       (tx_head),
        .fill       (tx_fill),
        .fill_after (tx_fill_after)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.read_byte    = rsp_reg.read_byte;
    assign rsp.send_valid   = rsp_reg.send_valid;
    assign rsp.send_byte    = rsp_reg.send_byte;
    assign rsp.push_dropped = rsp_reg.push_dropped;
    assign rsp.rx_level     = rsp_reg.rx_level;
    assign rsp.tx_level     = rsp_reg.tx_level;

endmodule

/* rtl/uartrb_checker.sv */
// ----------------------------------------------------------------------------
// uartrb_checker
// Port-level checks on the ring buffer block's result channel, attached to
// the top level by the bind at the end of this file.
// ----------------------------------------------------------------------------
module uartrb_checker #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [uartrb_pkg::BYTE_W-1:0]  read_byte,
    input logic                           send_valid,
    input logic [uartrb_pkg::BYTE_W-1:0]  send_byte,
    input logic                           push_dropped,
    input logic [uartrb_pkg::LEVEL_W-1:0] rx_level,
    input logic [uartrb_pkg::LEVEL_W-1:0] tx_level
);

    import uartrb_pkg::*;

    // a stalled result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte)
            && $stable(send_valid) && $stable(send_byte)
            && $stable(push_dropped) && $stable(rx_level) && $stable(tx_level))
    else $error("stalled result changed");

    // no byte goes to the line without send_valid
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !send_valid |-> send_byte == '0)
    else $error("send_byte set without send_valid");

    // a line send and a get never come from the same operation
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && send_valid |-> read_byte == '0)
    else $error("read_byte set alongside a send");

    // reported levels never exceed the queue depths
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rx_level) <= RX_DEPTH) && (int'(tx_level) <= TX_DEPTH))
    else $error("queue level beyond depth");

endmodule

bind uart_tx_rx_ring_buffers uartrb_checker #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .read_byte    (rsp.read_byte),
    .send_valid   (rsp.send_valid),
    .send_byte    (rsp.send_byte),
    .push_dropped (rsp.push_dropped),
    .rx_level     (rsp.rx_level),
    .tx_level     (rsp.tx_level)
);
